### design/nca_pkg.sv
// ----------------------------------------------------------------------------
// nca_pkg: shared types and constants for the nearest codeword assignment
// Default sizes, command codes passed from front to back, and register indexes.
// ----------------------------------------------------------------------------
package nca_pkg;

  // Default sizes
  localparam int MAX_CENTERS  = 1024;
  localparam int MAX_DIM      = 128;
  localparam int ELEMENT_BITS = 16;

  // Fixed field widths
  localparam int NORM_W      = 48;
  localparam int SCORE_W     = 49;
  localparam int CENTER_W    = 10;
  localparam int ELEM_IDX_W  = 7;
  localparam int OP_W        = 2;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int COUNT_W     = 11;
  localparam int LENGTH_W    = 8;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Input op codes
  localparam logic [OP_W-1:0] OP_CODEBOOK = 2'd0;
  localparam logic [OP_W-1:0] OP_NORM     = 2'd1;
  localparam logic [OP_W-1:0] OP_FEATURE  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_COUNT   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_LENGTH = 8'd1;

  // Reset values of the configuration registers
  localparam logic [COUNT_W-1:0]  CENTER_COUNT_RESET   = 11'd1024;
  localparam logic [LENGTH_W-1:0] FEATURE_LENGTH_RESET = 8'd100;

  // Command kinds carried through the queue
  typedef enum logic [1:0] {
    CMD_CODEBOOK = 2'd0,
    CMD_NORM     = 2'd1,
    CMD_FEATURE  = 2'd2,
    CMD_SEARCH   = 2'd3
  } cmd_kind_t;

  localparam int KIND_W = 2;

  // Back-end control states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } back_state_t;

endpackage

### design/nca_front.sv
// ----------------------------------------------------------------------------
// nca_front: input classifier
// Checks each accepted item, drops unused ops and out-of-range addresses, and
// packs it as a command; a feature element at the last index becomes a search.
// ----------------------------------------------------------------------------
module nca_front #(
  parameter int MAX_CENTERS  = nca_pkg::MAX_CENTERS,
  parameter int MAX_DIM      = nca_pkg::MAX_DIM,
  parameter int ELEMENT_BITS = nca_pkg::ELEMENT_BITS,
  parameter int CW           = 10,
  parameter int DW           = 7,
  parameter int CMD_W        = 8
) (
  input  logic                                     start,
  input  logic                                     busy,
  input  logic [nca_pkg::OP_W-1:0]                 op,
  input  logic [nca_pkg::CENTER_W-1:0]             center_index,
  input  logic [nca_pkg::ELEM_IDX_W-1:0]           element_index,
  input  logic signed [ELEMENT_BITS-1:0]           element_value,
  input  logic signed [nca_pkg::NORM_W-1:0]        norm_value,
  input  logic [DW-1:0]                            len_last,
  output logic                                     push,
  output logic [CMD_W-1:0]                         cmd
);

  nca_pkg::cmd_kind_t kind;
  logic               keep;
  logic               center_ok;
  logic               elem_ok;

  assign center_ok = 32'(center_index) < MAX_CENTERS;
  assign elem_ok   = 32'(element_index) < MAX_DIM;

  // Classify the item
  always_comb begin
    kind = nca_pkg::CMD_FEATURE;
    keep = 1'b0;
    case (op)
      nca_pkg::OP_CODEBOOK: begin
        kind = nca_pkg::CMD_CODEBOOK;
        keep = center_ok && elem_ok;
      end
      nca_pkg::OP_NORM: begin
        kind = nca_pkg::CMD_NORM;
        keep = center_ok;
      end
      nca_pkg::OP_FEATURE: begin
        keep = elem_ok;
        if (32'(element_index) == 32'(len_last)) begin
          kind = nca_pkg::CMD_SEARCH;
        end else begin
          kind = nca_pkg::CMD_FEATURE;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Transfer into the queue only for items that do something
  assign push = start && !busy && keep;
  assign cmd  = {kind, CW'(center_index), DW'(element_index), element_value, norm_value};

endmodule

### design/nca_queue.sv
// ----------------------------------------------------------------------------
// nca_queue: command queue
// Short register FIFO between the classifier and the search engine.
// ----------------------------------------------------------------------------
module nca_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nca_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             not_empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign not_empty = fill != '0;
  assign full      = fill == NW'(DEPTH);
  assign head      = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### design/nca_back.sv
// ----------------------------------------------------------------------------
// nca_back: search engine
// Holds codebook, norms and feature buffer; carries out writes and runs the
// multiply-accumulate search over all centers, keeping the best score.
// ----------------------------------------------------------------------------
module nca_back #(
  parameter int ELEMENT_BITS = nca_pkg::ELEMENT_BITS,
  parameter int CW           = 10,
  parameter int DW           = 7,
  parameter int CMD_W        = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  logic [CMD_W-1:0]                     cmd,
  output logic                                 cmd_pop,
  input  logic [DW-1:0]                        len_last,
  input  logic [CW-1:0]                        cnt_last,
  output logic                                 done,
  output logic [nca_pkg::CENTER_W-1:0]         assignment,
  output logic signed [nca_pkg::SCORE_W-1:0]   best_score
);

  localparam int SW     = nca_pkg::SCORE_W;
  localparam int NW     = nca_pkg::NORM_W;
  localparam int EB     = ELEMENT_BITS;
  localparam int CB_AW  = CW + DW;

  // Unpacked command
  logic [nca_pkg::KIND_W-1:0] c_kind_bits;
  nca_pkg::cmd_kind_t         c_kind;
  logic [CW-1:0]              c_center;
  logic [DW-1:0]              c_elem;
  logic signed [EB-1:0]       c_value;
  logic signed [NW-1:0]       c_norm;

  assign {c_kind_bits, c_center, c_elem, c_value, c_norm} = cmd;
  assign c_kind = nca_pkg::cmd_kind_t'(c_kind_bits);

  // Memories
  logic signed [EB-1:0] cb_mem   [1 << CB_AW];
  logic signed [NW-1:0] norm_mem [1 << CW];
  logic signed [EB-1:0] fb_mem   [1 << DW];

  nca_pkg::back_state_t state;
  logic [CW-1:0]        ctr_c;
  logic [DW-1:0]        ctr_k;
  logic                 k_last;
  logic                 issue_fin;

  // Stage 1: read data
  logic signed [EB-1:0] cb_rd;
  logic signed [EB-1:0] fb_rd;
  logic signed [NW-1:0] nm_rd;
  logic                 s1_valid, s1_first, s1_last, s1_fin;
  logic [CW-1:0]        s1_center;
  // Stage 2: product
  logic signed [2*EB-1:0] prod;
  logic signed [NW-1:0]   s2_norm;
  logic                   s2_valid, s2_first, s2_last, s2_fin;
  logic [CW-1:0]          s2_center;
  // Stage 3: accumulator
  logic signed [SW-1:0] acc;
  logic signed [NW-1:0] s3_norm;
  logic                 s3_valid, s3_last, s3_fin;
  logic [CW-1:0]        s3_center;
  // Stage 4: score
  logic signed [SW-1:0] score;
  logic                 s4_valid, s4_fin;
  logic [CW-1:0]        s4_center;
  // Best so far
  logic signed [SW-1:0] best;
  logic [CW-1:0]        best_c;

  logic write_now;

  assign cmd_pop   = (state == nca_pkg::ST_IDLE) && cmd_valid;
  assign write_now = cmd_pop;
  assign k_last    = ctr_k == len_last;
  assign issue_fin = k_last && (ctr_c == cnt_last);

  // Codebook: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (write_now && c_kind == nca_pkg::CMD_CODEBOOK) begin
      cb_mem[{c_center, c_elem}] <= c_value;
    end
    cb_rd <= cb_mem[{ctr_c, ctr_k}];
  end

  // Norm terms
  always_ff @(posedge clk) begin
    if (write_now && c_kind == nca_pkg::CMD_NORM) begin
      norm_mem[c_center] <= c_norm;
    end
    nm_rd <= norm_mem[ctr_c];
  end

  // Feature buffer
  always_ff @(posedge clk) begin
    if (write_now && (c_kind == nca_pkg::CMD_FEATURE || c_kind == nca_pkg::CMD_SEARCH)) begin
      fb_mem[c_elem] <= c_value;
    end
    fb_rd <= fb_mem[ctr_k];
  end

  // Sequencer: walks centers and elements
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= nca_pkg::ST_IDLE;
      ctr_c    <= '0;
      ctr_k    <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      case (state)
        nca_pkg::ST_IDLE: begin
          ctr_c <= '0;
          ctr_k <= '0;
          if (cmd_pop && c_kind == nca_pkg::CMD_SEARCH) begin
            state <= nca_pkg::ST_RUN;
          end
        end
        nca_pkg::ST_RUN: begin
          s1_valid <= 1'b1;
          if (k_last) begin
            ctr_k <= '0;
            ctr_c <= ctr_c + 1'b1;
          end else begin
            ctr_k <= ctr_k + 1'b1;
          end
          if (issue_fin) begin
            state <= nca_pkg::ST_DRAIN;
          end
        end
        nca_pkg::ST_DRAIN: begin
          if (s4_valid && s4_fin) begin
            state <= nca_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= nca_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Stage 1 tags travel with the read data
  always_ff @(posedge clk) begin
    s1_first  <= ctr_k == '0;
    s1_last   <= k_last;
    s1_fin    <= issue_fin;
    s1_center <= ctr_c;
  end

  // Stage 2: multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    prod      <= fb_rd * cb_rd;
    s2_norm   <= nm_rd;
    s2_first  <= s1_first;
    s2_last   <= s1_last;
    s2_fin    <= s1_fin;
    s2_center <= s1_center;
  end

  // Stage 3: accumulate, restarting at each center's first element
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    if (s2_valid) begin
      if (s2_first) begin
        acc <= SW'(prod);
      end else begin
        acc <= acc + SW'(prod);
      end
    end
    s3_norm   <= s2_norm;
    s3_last   <= s2_last;
    s3_fin    <= s2_fin;
    s3_center <= s2_center;
  end

  // Stage 4: subtract the norm at the end of each center
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid && s3_last;
    end
    score     <= acc - SW'(s3_norm);
    s4_fin    <= s3_fin;
    s4_center <= s3_center;
  end

  // Keep the best score; earliest wins on ties, center 0 always taken
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid && s4_fin;
    end
    if (s4_valid && (s4_center == '0 || score > best)) begin
      best   <= score;
      best_c <= s4_center;
    end
  end

  assign assignment = nca_pkg::CENTER_W'(best_c);
  assign best_score = best;

endmodule

### design/nearest_codeword_assignment.sv
// ----------------------------------------------------------------------------
// nearest_codeword_assignment: vector-quantization encoder
// Finds the codebook center with the largest dot product minus norm for a
// feature vector and reports its index and score.
// ----------------------------------------------------------------------------
// Use:
//   Items are accepted when start is high and busy is low. op 0 writes a
//   codebook element, op 1 a center norm, op 2 a feature element; others drop.
//   Writes and plain feature elements pass through a 4-entry command queue and
//   are carried out by the engine at one per cycle while no search is running.
//   The feature element at index feature_length-1 starts a search: one
//   multiply-accumulate per cycle over center_count x feature_length element
//   pairs (each count saturated to the supported range), all on the single
//   MAC in the engine. Items keep being accepted during a search until the
//   queue fills; busy is then high.
//   done is high for one cycle with assignment and best_score valid; the
//   receiver cannot stall, so it must take the result in that cycle.
//   Configuration: cfg_ready is always high; index 0 is center_count, index 1
//   is feature_length, other indexes are ignored. Write only while idle.
//   Reset clears control state and restores the register defaults; the
//   codebook, norms and feature buffer hold nothing defined until written.
// ----------------------------------------------------------------------------
module nearest_codeword_assignment #(
  parameter int MAX_CENTERS  = nca_pkg::MAX_CENTERS,
  parameter int MAX_DIM      = nca_pkg::MAX_DIM,
  parameter int ELEMENT_BITS = nca_pkg::ELEMENT_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [nca_pkg::OP_W-1:0]               op,
  input  logic [nca_pkg::CENTER_W-1:0]           center_index,
  input  logic [nca_pkg::ELEM_IDX_W-1:0]         element_index,
  input  logic signed [ELEMENT_BITS-1:0]         element_value,
  input  logic signed [nca_pkg::NORM_W-1:0]      norm_value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [nca_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [nca_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic                                   done,
  output logic [nca_pkg::CENTER_W-1:0]           assignment,
  output logic signed [nca_pkg::SCORE_W-1:0]     best_score
);

  localparam int CW    = $clog2(MAX_CENTERS);
  localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CMD_W = nca_pkg::KIND_W + CW + DW + ELEMENT_BITS + nca_pkg::NORM_W;

  logic [nca_pkg::COUNT_W-1:0]  center_count;
  logic [nca_pkg::LENGTH_W-1:0] feature_length;
  logic [DW-1:0]                len_last;
  logic [CW-1:0]                cnt_last;

  logic             push;
  logic [CMD_W-1:0] push_cmd;
  logic             pop;
  logic [CMD_W-1:0] head_cmd;
  logic             not_empty;
  logic             full;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_count   <= nca_pkg::CENTER_COUNT_RESET;
      feature_length <= nca_pkg::FEATURE_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nca_pkg::REG_CENTER_COUNT: begin
          center_count <= cfg_data[nca_pkg::COUNT_W-1:0];
        end
        nca_pkg::REG_FEATURE_LENGTH: begin
          feature_length <= cfg_data[nca_pkg::LENGTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Effective last indexes, saturated to the supported range
  always_comb begin
    if (feature_length == '0) begin
      len_last = '0;
    end else if (32'(feature_length) > MAX_DIM) begin
      len_last = DW'(MAX_DIM - 1);
    end else begin
      len_last = DW'(feature_length - 1'b1);
    end
    if (center_count == '0) begin
      cnt_last = '0;
    end else if (32'(center_count) > MAX_CENTERS) begin
      cnt_last = CW'(MAX_CENTERS - 1);
    end else begin
      cnt_last = CW'(center_count - 1'b1);
    end
  end

  assign busy = full;

  nca_front #(
    .MAX_CENTERS  (MAX_CENTERS),
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS),
    .CW           (CW),
    .DW           (DW),
    .CMD_W        (CMD_W)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .op            (op),
    .center_index  (center_index),
    .element_index (element_index),
    .element_value (element_value),
    .norm_value    (norm_value),
    .len_last      (len_last),
    .push          (push),
    .cmd           (push_cmd)
  );

  nca_queue #(
    .WIDTH (CMD_W),
    .DEPTH (nca_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head_cmd),
    .not_empty (not_empty),
    .full      (full)
  );

  nca_back #(
    .ELEMENT_BITS (ELEMENT_BITS),
    .CW           (CW),
    .DW           (DW),
    .CMD_W        (CMD_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (not_empty),
    .cmd        (head_cmd),
    .cmd_pop    (pop),
    .len_last   (len_last),
    .cnt_last   (cnt_last),
    .done       (done),
    .assignment (assignment),
    .best_score (best_score)
  );

endmodule
